>>> hdl/lsdrs_pkg.sv
package lsdrs_pkg;

   localparam int MAX_ITEMS    = 32;
   localparam int DIGIT_PASSES = 3;
   localparam int RADIX        = 10;

   localparam int SCORE_W = 10;
   localparam int TAG_W   = 16;
   localparam int IDX_W   = $clog2(MAX_ITEMS);
   localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
   localparam int PASS_W  = $clog2(DIGIT_PASSES + 1);
   localparam int DIGIT_W = $clog2(RADIX);

   // x / 10 == (x * 205) >> 11 for every x below 1029
   localparam int DIV_MUL   = 205;
   localparam int DIV_SHIFT = 11;
   localparam int PROD_W    = SCORE_W + 8;

   localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(RADIX - 1);
   localparam logic [PASS_W-1:0]  LAST_PASS  = PASS_W'(DIGIT_PASSES - 1);
   localparam logic [CNT_W-1:0]   FULL_COUNT = CNT_W'(MAX_ITEMS);

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [TAG_W-1:0]   tag;
      logic [SCORE_W-1:0] rem;
   } rec_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_COUNT,
      ST_PREFIX,
      ST_PLACE,
      ST_EMIT
   } state_type;

endpackage

>>> hdl/lsdrs_if.sv
interface lsdrs_req_if import lsdrs_pkg::*;;
   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] score;
   logic [TAG_W-1:0]   tag;
   logic               last;

   modport source (output valid, score, tag, last, input ready);
   modport sink   (input valid, score, tag, last, output ready);
endinterface

interface lsdrs_rsp_if import lsdrs_pkg::*;;
   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] sorted_score;
   logic [TAG_W-1:0]   sorted_tag;
   logic               final_res;
   logic               dropped;

   modport source (output valid, sorted_score, sorted_tag, final_res, dropped, input ready);
   modport sink   (input valid, sorted_score, sorted_tag, final_res, dropped, output ready);
endinterface

>>> hdl/lsd_decimal_radix_sort.sv
// Stable base-10 radix sort of up to MAX_ITEMS score/tag words. Words load one
// per cycle while req_chan.ready is high; the word with last set closes the set
// and starts the sort, after which the block is not ready until the sorted run
// has been handed to the output register. Each of the three digit passes (units,
// tens, hundreds) is a count sweep and a place sweep over the single-read banks,
// with one shared divide-by-ten unit peeling the next digit, and a prefix sum
// over the digit counters between the two sweeps. The run then leaves through
// the registered bank read, which reads the next word only once the last has
// reached the output register and that register is free or being taken. Words past
// capacity are discarded and dropped is set on every word of that run; scores of
// 1000 and above sort by their value modulo 1000 and are returned unchanged.
module lsd_decimal_radix_sort import lsdrs_pkg::*; (
   input logic         clock,
   input logic         reset,
   lsdrs_req_if.sink   req_chan,
   lsdrs_rsp_if.source rsp_chan
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [PASS_W-1:0]  pass_ff, pass_in;
   logic               src_ff, src_in;
   logic [CNT_W-1:0]   iss_ff, iss_in;
   logic               vld_ff, vld_in;
   logic               pend_last_ff, pend_last_in;
   logic [DIGIT_W-1:0] dig_ff, dig_in;
   logic [CNT_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   counts_ff [RADIX];
   logic [CNT_W-1:0]   counts_in [RADIX];

   logic               out_vld_ff, out_vld_in;
   logic [SCORE_W-1:0] out_score_ff, out_score_in;
   logic [TAG_W-1:0]   out_tag_ff, out_tag_in;
   logic               out_final_ff, out_final_in;
   logic               out_drop_ff, out_drop_in;

   logic               req_ready;
   logic               req_take;
   logic               rsp_take;
   logic               issue;
   logic               phase_end;

   logic               wr_en_a, wr_en_b;
   logic [IDX_W-1:0]   wr_addr;
   rec_type            wr_data;
   rec_type            rd_a, rd_b, rd_rec;
   logic [SCORE_W-1:0] quot;
   logic [DIGIT_W-1:0] digit;

   lsdrs_bank u_bank_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (rd_a)
   );

   lsdrs_bank u_bank_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (rd_b)
   );

   assign rd_rec = src_ff ? rd_b : rd_a;

   lsdrs_div10 u_div10 (
      .value (rd_rec.rem),
      .quot  (quot),
      .digit (digit)
   );

   assign req_take = req_chan.valid && req_ready;
   assign rsp_take = out_vld_ff && rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take && req_chan.last) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (phase_end) begin
               state_in = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            if (dig_ff == LAST_DIGIT) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (phase_end) begin
               state_in = (pass_ff == LAST_PASS) ? ST_EMIT : ST_COUNT;
            end
         end
         ST_EMIT: begin
            if (phase_end) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      phase_end = (iss_ff == count_ff) && !vld_ff;
      case (state_ff)
         ST_LOAD:  req_ready = 1'b1;
         ST_COUNT: issue = iss_ff < count_ff;
         ST_PLACE: issue = iss_ff < count_ff;
         ST_EMIT:  issue = (iss_ff < count_ff) && !vld_ff && (!out_vld_ff || rsp_chan.ready);
         default: begin
            req_ready = 1'b0;
            issue     = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      pass_in      = pass_ff;
      src_in       = src_ff;
      iss_in       = issue ? CNT_W'(iss_ff + 1'b1) : iss_ff;
      vld_in       = issue;
      pend_last_in = pend_last_ff;
      dig_in       = dig_ff;
      sum_in       = sum_ff;
      counts_in    = counts_ff;
      out_vld_in   = out_vld_ff;
      out_score_in = out_score_ff;
      out_tag_in   = out_tag_ff;
      out_final_in = out_final_ff;
      out_drop_in  = out_drop_ff;
      wr_en_a      = 1'b0;
      wr_en_b      = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = '{score: req_chan.score, tag: req_chan.tag, rem: req_chan.score};

      if (rsp_take) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (count_ff < FULL_COUNT) begin
                  wr_en_a  = 1'b1;
                  count_in = CNT_W'(count_ff + 1'b1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last) begin
                  iss_in  = '0;
                  pass_in = '0;
                  src_in  = 1'b0;
                  for (int d = 0; d < RADIX; d++) begin
                     counts_in[d] = '0;
                  end
               end
            end
         end
         ST_COUNT: begin
            if (vld_ff) begin
               counts_in[digit] = CNT_W'(counts_ff[digit] + 1'b1);
            end
            if (phase_end) begin
               dig_in = '0;
               sum_in = '0;
            end
         end
         ST_PREFIX: begin
            counts_in[dig_ff] = sum_ff;
            sum_in            = CNT_W'(sum_ff + counts_ff[dig_ff]);
            dig_in            = DIGIT_W'(dig_ff + 1'b1);
            iss_in            = '0;
         end
         ST_PLACE: begin
            wr_addr = counts_ff[digit][IDX_W-1:0];
            wr_data = '{score: rd_rec.score, tag: rd_rec.tag, rem: quot};
            if (vld_ff) begin
               wr_en_a          = src_ff;
               wr_en_b          = !src_ff;
               counts_in[digit] = CNT_W'(counts_ff[digit] + 1'b1);
            end
            if (phase_end) begin
               src_in  = !src_ff;
               pass_in = PASS_W'(pass_ff + 1'b1);
               iss_in  = '0;
               for (int d = 0; d < RADIX; d++) begin
                  counts_in[d] = '0;
               end
            end
         end
         ST_EMIT: begin
            if (issue) begin
               pend_last_in = (iss_ff == CNT_W'(count_ff - 1'b1));
            end
            if (vld_ff) begin
               out_vld_in   = 1'b1;
               out_score_in = rd_rec.score;
               out_tag_in   = rd_rec.tag;
               out_final_in = pend_last_ff;
               out_drop_in  = ovf_ff;
            end
            if (phase_end) begin
               count_in = '0;
               ovf_in   = 1'b0;
               iss_in   = '0;
            end
         end
         default: begin
            iss_in = '0;
            vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         pass_ff    <= '0;
         src_ff     <= 1'b0;
         iss_ff     <= '0;
         vld_ff     <= 1'b0;
         dig_ff     <= '0;
         sum_ff     <= '0;
         out_vld_ff <= 1'b0;
         for (int d = 0; d < RADIX; d++) begin
            counts_ff[d] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         pass_ff    <= pass_in;
         src_ff     <= src_in;
         iss_ff     <= iss_in;
         vld_ff     <= vld_in;
         dig_ff     <= dig_in;
         sum_ff     <= sum_in;
         out_vld_ff <= out_vld_in;
         counts_ff  <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      out_score_ff <= out_score_in;
      out_tag_ff   <= out_tag_in;
      out_final_ff <= out_final_in;
      out_drop_ff  <= out_drop_in;
   end

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.sorted_score = out_score_ff;
   assign rsp_chan.sorted_tag   = out_tag_ff;
   assign rsp_chan.final_res    = out_final_ff;
   assign rsp_chan.dropped      = out_drop_ff;

endmodule

>>> hdl/lsdrs_div10.sv
module lsdrs_div10 import lsdrs_pkg::*; (
   input  logic [SCORE_W-1:0] value,
   output logic [SCORE_W-1:0] quot,
   output logic [DIGIT_W-1:0] digit
);

   logic [PROD_W-1:0]  prod;
   logic [SCORE_W-1:0] tenfold;

   always_comb begin
      prod    = PROD_W'(value) * PROD_W'(DIV_MUL);
      quot    = SCORE_W'(prod >> DIV_SHIFT);
      tenfold = SCORE_W'((quot << 3) + (quot << 1));
      digit   = DIGIT_W'(value - tenfold);
   end

endmodule

>>> hdl/lsdrs_bank.sv
module lsdrs_bank import lsdrs_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  rec_type          wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output rec_type          rd_data
);

   rec_type mem_ff [MAX_ITEMS];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
